// File: sv/s3i_pkg.sv
package s3i_pkg;

    // Distinct entries of a symmetric 3x3 matrix, and of its adjugate,
    // in the order 00, 01, 02, 11, 12, 22.
    localparam int LANES = 6;

    // Cross products needed for the six cofactors (two per cofactor).
    localparam int PRODS = 2 * LANES;

    // Entries of the first row, used for the cofactor expansion of det.
    localparam int ROW = 3;

endpackage

// File: sv/s3i_if.sv
interface s3i_mat_if #(parameter int DATA_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] m00;
    logic signed [DATA_BITS-1:0] m01;
    logic signed [DATA_BITS-1:0] m02;
    logic signed [DATA_BITS-1:0] m11;
    logic signed [DATA_BITS-1:0] m12;
    logic signed [DATA_BITS-1:0] m22;

    modport source (output valid, m00, m01, m02, m11, m12, m22, input ready);
    modport sink   (input valid, m00, m01, m02, m11, m12, m22, output ready);
endinterface

interface s3i_res_if #(parameter int DATA_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] det_value;
    logic signed [DATA_BITS-1:0] inv00;
    logic signed [DATA_BITS-1:0] inv01;
    logic signed [DATA_BITS-1:0] inv02;
    logic signed [DATA_BITS-1:0] inv11;
    logic signed [DATA_BITS-1:0] inv12;
    logic signed [DATA_BITS-1:0] inv22;
    logic                        singular;
    logic                        saturated;

    modport source (output valid, det_value, inv00, inv01, inv02, inv11, inv12, inv22,
                    singular, saturated, input ready);
    modport sink   (input valid, det_value, inv00, inv01, inv02, inv11, inv12, inv22,
                    singular, saturated, output ready);
endinterface

// File: sv/s3i_div_stage.sv
module s3i_div_stage #(
    parameter int DB = 99,
    parameter int K  = 33,
    parameter int SB = 46
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  logic [DB-1:0] dm_in,
    input  logic [DB-1:0] rem_in  [s3i_pkg::LANES],
    input  logic [K-1:0]  lo_in   [s3i_pkg::LANES],
    input  logic [K-1:0]  q_in    [s3i_pkg::LANES],
    input  logic [SB-1:0] side_in,
    output logic          valid_out,
    output logic [DB-1:0] dm_out,
    output logic [DB-1:0] rem_out [s3i_pkg::LANES],
    output logic [K-1:0]  lo_out  [s3i_pkg::LANES],
    output logic [K-1:0]  q_out   [s3i_pkg::LANES],
    output logic [SB-1:0] side_out
);
    import s3i_pkg::*;

    // one restoring step per lane: bring in the next numerator bit, try subtract
    logic [DB:0]   trial   [LANES];
    logic [DB:0]   diff    [LANES];
    logic          take    [LANES];
    logic [DB-1:0] rem_next [LANES];
    logic [K-1:0]  lo_next  [LANES];
    logic [K-1:0]  q_next   [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trial[l]    = {rem_in[l], lo_in[l][K-1]};
            diff[l]     = trial[l] - {1'b0, dm_in};
            take[l]     = (trial[l] >= {1'b0, dm_in});
            rem_next[l] = take[l] ? diff[l][DB-1:0] : trial[l][DB-1:0];
            lo_next[l]  = {lo_in[l][K-2:0], 1'b0};
            q_next[l]   = {q_in[l][K-2:0], take[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_out   <= dm_in;
            rem_out  <= rem_next;
            lo_out   <= lo_next;
            q_out    <= q_next;
            side_out <= side_in;
        end
    end

endmodule

// File: sv/symmetric_3x3_inverse.sv
// Symmetric 3x3 inverse, adjugate over determinant, signed fixed point
// (DATA_BITS wide, FRAC_BITS fraction bits; Q16.16 by default). One matrix
// transfer is taken every clock cycle unless the pipeline is full and the
// output stalled, and one result transfer leaves per matrix, in order. The
// stages are: one of cross products, one of cofactor subtraction, two for
// the split first-row products, one for the determinant sum, one for
// magnitudes, one for determinant rounding and divider set-up, then a
// DATA_BITS + 1 stage restoring divider (one quotient bit per stage, six
// lanes side by side) and the output register where quotients are rounded
// and clipped. Bubbles close up while the output is stalled, so the input
// keeps accepting until every stage holds an item. Determinant and inverse
// entries round to nearest with ties away from zero and clip to the output
// range, which raises saturated. A determinant that is exactly zero gives
// singular with all values zero; a tiny but nonzero one is not singular and
// usually clips.
module symmetric_3x3_inverse #(
    parameter int DATA_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    s3i_mat_if.sink   mat,
    s3i_res_if.source res
);
    import s3i_pkg::*;

    localparam int W  = DATA_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PB = 2 * W;           // cross product
    localparam int CB = 2 * W + 1;       // cofactor
    localparam int HB = 2 * W + 1;       // split product m * cofactor half
    localparam int TB = 3 * W + 1;       // m * cofactor
    localparam int DB = 3 * W + 3;       // determinant, and its magnitude
    localparam int K  = W + 1;           // quotient bits
    localparam int NB = CB + 2 * F;      // scaled cofactor magnitude
    localparam int XB = NB + DB + 1;     // room for the overflow compare
    localparam int SB = 2 * LANES + W + 2;

    localparam logic [W-1:0]  SMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [DB:0]   DHALF = (DB+1)'(1) << (2 * F - 1);

    // ---------------------------------------------------------------- enables
    // A stage loads when it is empty or its successor loads.
    logic en1, en2, en3, en4, en5, en6, en7, en_o;
    wire  [K-1:0] en_div;
    wire  [K-1:0] dv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vo_reg;

    assign en_o = !vo_reg || res.ready;
    assign en7  = !v7_reg || en_div[0];
    assign en6  = !v6_reg || en7;
    assign en5  = !v5_reg || en6;
    assign en4  = !v4_reg || en5;
    assign en3  = !v3_reg || en4;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;

    assign mat.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)  v1_reg <= mat.valid;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en4)  v4_reg <= v3_reg;
            if (en5)  v5_reg <= v4_reg;
            if (en6)  v6_reg <= v5_reg;
            if (en7)  v7_reg <= v6_reg;
            if (en_o) vo_reg <= dv[K-1];
        end
    end

    // ------------------------------------------------ stage 1: cross products
    logic signed [PB-1:0] prod_next [PRODS];
    logic signed [PB-1:0] prod_reg  [PRODS];
    logic signed [W-1:0]  row_next  [ROW];
    logic signed [W-1:0]  row1_reg  [ROW];

    always_comb
    begin
        // pairs in cofactor order: minuend then subtrahend
        prod_next[0]  = mat.m11 * mat.m22;
        prod_next[1]  = mat.m12 * mat.m12;
        prod_next[2]  = mat.m02 * mat.m12;
        prod_next[3]  = mat.m01 * mat.m22;
        prod_next[4]  = mat.m01 * mat.m12;
        prod_next[5]  = mat.m02 * mat.m11;
        prod_next[6]  = mat.m00 * mat.m22;
        prod_next[7]  = mat.m02 * mat.m02;
        prod_next[8]  = mat.m01 * mat.m02;
        prod_next[9]  = mat.m00 * mat.m12;
        prod_next[10] = mat.m00 * mat.m11;
        prod_next[11] = mat.m01 * mat.m01;
        row_next[0]   = mat.m00;
        row_next[1]   = mat.m01;
        row_next[2]   = mat.m02;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg <= prod_next;
            row1_reg <= row_next;
        end
    end

    // ----------------------------------------------------- stage 2: cofactors
    logic signed [CB-1:0] cof_next [LANES];
    logic signed [CB-1:0] cof2_reg [LANES];
    logic signed [W-1:0]  row2_reg [ROW];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            cof_next[l] = prod_reg[2*l] - prod_reg[2*l+1];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            cof2_reg <= cof_next;
            row2_reg <= row1_reg;
        end
    end

    // ------------------------- stage 3: first row times cofactor, two halves
    logic signed [HB-1:0] plo_next [ROW];
    logic signed [HB-1:0] phi_next [ROW];
    logic signed [HB-1:0] plo_reg  [ROW];
    logic signed [HB-1:0] phi_reg  [ROW];
    logic signed [CB-1:0] cof3_reg [LANES];

    always_comb
    begin
        for (int r = 0; r < ROW; r++)
        begin
            plo_next[r] = row2_reg[r] * $signed({1'b0, cof2_reg[r][W-1:0]});
            phi_next[r] = row2_reg[r] * $signed(cof2_reg[r][CB-1:W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            cof3_reg <= cof2_reg;
        end
    end

    // ------------------------------------------------ stage 4: join the halves
    logic signed [TB-1:0] term_next [ROW];
    logic signed [TB-1:0] term_reg  [ROW];
    logic signed [CB-1:0] cof4_reg  [LANES];

    always_comb
    begin
        for (int r = 0; r < ROW; r++)
            term_next[r] = $signed({phi_reg[r], {W{1'b0}}}) + plo_reg[r];
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            term_reg <= term_next;
            cof4_reg <= cof3_reg;
        end
    end

    // --------------------------------------------------- stage 5: determinant
    logic signed [DB-1:0] det_next;
    logic signed [DB-1:0] det_reg;
    logic signed [CB-1:0] cof5_reg [LANES];

    always_comb
    begin
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            det_reg  <= det_next;
            cof5_reg <= cof4_reg;
        end
    end

    // ---------------------------------------------------- stage 6: magnitudes
    logic [DB-1:0] dmag_next, dmag_reg;
    logic          dneg_reg, dzero_reg;
    logic [CB-1:0] cmag_next [LANES];
    logic [CB-1:0] cmag_reg  [LANES];
    logic [LANES-1:0] cneg_next, cneg_reg;

    always_comb
    begin
        dmag_next = det_reg[DB-1] ? DB'(-det_reg) : DB'(det_reg);
        for (int l = 0; l < LANES; l++)
        begin
            cneg_next[l] = cof5_reg[l][CB-1];
            cmag_next[l] = cneg_next[l] ? CB'(-cof5_reg[l]) : CB'(cof5_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            dmag_reg  <= dmag_next;
            dneg_reg  <= det_reg[DB-1];
            dzero_reg <= (det_reg == '0);
            cmag_reg  <= cmag_next;
            cneg_reg  <= cneg_next;
        end
    end

    // -------------------- stage 7: round det, scale numerators, seed divider
    logic [DB:0]      drnd;
    logic [DB:0]      dq;
    logic [DB:0]      dlim;
    logic             dsat;
    logic [W-1:0]     dval;
    logic [XB-1:0]    nx   [LANES];
    logic [XB-1:0]    dmx;
    logic [LANES-1:0] ovf_next;
    logic [LANES-1:0] lneg_next;
    logic [DB-1:0]    rem0_next [LANES];
    logic [K-1:0]     lo0_next  [LANES];

    always_comb
    begin
        drnd = {1'b0, dmag_reg} + DHALF;
        dq   = drnd >> (2 * F);
        dlim = dneg_reg ? (DB+1)'(SMIN) : (DB+1)'(SMAX);
        dsat = (dq > dlim);
        if (dsat)
            dval = dneg_reg ? SMIN : SMAX;
        else
            dval = dneg_reg ? W'(-dq[W-1:0]) : dq[W-1:0];

        dmx = XB'(dmag_reg) << K;
        for (int l = 0; l < LANES; l++)
        begin
            nx[l]        = XB'(cmag_reg[l]) << (2 * F);
            ovf_next[l]  = (nx[l] >= dmx);    // quotient needs more than K bits
            lneg_next[l] = cneg_reg[l] ^ dneg_reg;
            rem0_next[l] = DB'(nx[l] >> K);
            lo0_next[l]  = nx[l][K-1:0];
        end
    end

    logic [DB-1:0] s7_dm_reg;
    logic [DB-1:0] s7_rem_reg [LANES];
    logic [K-1:0]  s7_lo_reg  [LANES];
    logic [K-1:0]  q_zero     [LANES];
    logic [SB-1:0] s7_side_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            q_zero[l] = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            s7_dm_reg   <= dmag_reg;
            s7_rem_reg  <= rem0_next;
            s7_lo_reg   <= lo0_next;
            s7_side_reg <= {lneg_next, ovf_next, dval, dsat, dzero_reg};
        end
    end

    // ------------------------------------------ divider: one bit per stage
    wire [DB-1:0] d_dm   [K];
    wire [DB-1:0] d_rem  [K][LANES];
    wire [K-1:0]  d_lo   [K][LANES];
    wire [K-1:0]  d_q    [K][LANES];
    wire [SB-1:0] d_side [K];

    for (genvar j = 0; j < K; j++)
    begin : g_div
        if (j == K - 1)
        begin : g_last
            assign en_div[j] = !dv[j] || en_o;
        end
        else
        begin : g_mid
            assign en_div[j] = !dv[j] || en_div[j+1];
        end

        if (j == 0)
        begin : g_first
            s3i_div_stage #(.DB(DB), .K(K), .SB(SB)) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en_div[j]),
                .valid_in  (v7_reg),
                .dm_in     (s7_dm_reg),
                .rem_in    (s7_rem_reg),
                .lo_in     (s7_lo_reg),
                .q_in      (q_zero),
                .side_in   (s7_side_reg),
                .valid_out (dv[j]),
                .dm_out    (d_dm[j]),
                .rem_out   (d_rem[j]),
                .lo_out    (d_lo[j]),
                .q_out     (d_q[j]),
                .side_out  (d_side[j])
            );
        end
        else
        begin : g_next
            s3i_div_stage #(.DB(DB), .K(K), .SB(SB)) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en_div[j]),
                .valid_in  (dv[j-1]),
                .dm_in     (d_dm[j-1]),
                .rem_in    (d_rem[j-1]),
                .lo_in     (d_lo[j-1]),
                .q_in      (d_q[j-1]),
                .side_in   (d_side[j-1]),
                .valid_out (dv[j]),
                .dm_out    (d_dm[j]),
                .rem_out   (d_rem[j]),
                .lo_out    (d_lo[j]),
                .q_out     (d_q[j]),
                .side_out  (d_side[j])
            );
        end
    end

    // ------------------------------- output stage: round, clip, singular case
    logic [LANES-1:0] f_neg, f_ovf;
    logic [W-1:0]     f_det;
    logic             f_dsat, f_zero;
    logic             rnd   [LANES];
    logic [K:0]       qr    [LANES];
    logic [K:0]       qlim  [LANES];
    logic [LANES-1:0] lsat;
    logic [W-1:0]     inv_next [LANES];
    logic [W-1:0]     det_next_o;
    logic             sat_next;

    logic [W-1:0]     inv_reg [LANES];
    logic [W-1:0]     det_o_reg;
    logic             singular_reg, saturated_reg;

    always_comb
    begin
        {f_neg, f_ovf, f_det, f_dsat, f_zero} = d_side[K-1];
        for (int l = 0; l < LANES; l++)
        begin
            rnd[l]  = ({d_rem[K-1][l], 1'b0} >= {1'b0, d_dm[K-1]});
            qr[l]   = {1'b0, d_q[K-1][l]} + (K+1)'(rnd[l]);
            qlim[l] = f_neg[l] ? (K+1)'(SMIN) : (K+1)'(SMAX);
            lsat[l] = f_ovf[l] || (qr[l] > qlim[l]);
            if (f_zero)
                inv_next[l] = '0;
            else if (lsat[l])
                inv_next[l] = f_neg[l] ? SMIN : SMAX;
            else
                inv_next[l] = f_neg[l] ? W'(-qr[l][W-1:0]) : qr[l][W-1:0];
        end
        det_next_o = f_zero ? '0 : f_det;
        sat_next   = !f_zero && (f_dsat || (lsat != '0));
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            inv_reg       <= inv_next;
            det_o_reg     <= det_next_o;
            singular_reg  <= f_zero;
            saturated_reg <= sat_next;
        end
    end

    assign res.valid     = vo_reg;
    assign res.det_value = det_o_reg;
    assign res.inv00     = inv_reg[0];
    assign res.inv01     = inv_reg[1];
    assign res.inv02     = inv_reg[2];
    assign res.inv11     = inv_reg[3];
    assign res.inv12     = inv_reg[4];
    assign res.inv22     = inv_reg[5];
    assign res.singular  = singular_reg;
    assign res.saturated = saturated_reg;

endmodule

// File: sv/s3i_checker.sv
module s3i_checker #(
    parameter int DATA_BITS = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 mat_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [DATA_BITS-1:0] det_value,
    input logic [DATA_BITS-1:0] inv00,
    input logic [DATA_BITS-1:0] inv01,
    input logic [DATA_BITS-1:0] inv02,
    input logic [DATA_BITS-1:0] inv11,
    input logic [DATA_BITS-1:0] inv12,
    input logic [DATA_BITS-1:0] inv22,
    input logic                 singular,
    input logic                 saturated
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // and its determinant, inv00, inv22 and flags do not change under the stall
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(det_value) && $stable(inv00)
            && $stable(inv22) && $stable(singular) && $stable(saturated))
        else $error("result changed while stalled");

    // singular matrix: everything zero, nothing clipped
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && singular |-> det_value == '0 && inv00 == '0 && inv01 == '0
            && inv02 == '0 && inv11 == '0 && inv12 == '0 && inv22 == '0 && !saturated)
        else $error("singular result not cleared");

    // input only back-pressures when the output is stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !mat_ready |-> res_valid && !res_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind symmetric_3x3_inverse s3i_checker #(.DATA_BITS(DATA_BITS)) u_s3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_ready (mat.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .det_value (res.det_value),
    .inv00     (res.inv00),
    .inv01     (res.inv01),
    .inv02     (res.inv02),
    .inv11     (res.inv11),
    .inv12     (res.inv12),
    .inv22     (res.inv22),
    .singular  (res.singular),
    .saturated (res.saturated)
);

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import s3i_pkg::*;

    localparam int DATA_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int N_RANDOM   = 1700;
    localparam int STALL_LIMIT = 3000;  // cycles with no transfer at all
    localparam int DRAIN_WAIT  = DATA_BITS + 20;
    localparam int HOLD_CYCLES = 400;   // long output stall, well past the pipe depth

    typedef logic signed [DATA_BITS-1:0] fix_t;
    typedef logic signed [255:0]         wide_t;

    typedef struct {
        fix_t m00, m01, m02, m11, m12, m22;
    } matrix_t;

    typedef struct {
        fix_t det_value, inv00, inv01, inv02, inv11, inv12, inv22;
        logic singular, saturated;
    } inverse_t;

    // Scoreboard: exact adjugate/determinant prediction and in-order compare.
    class inverse_scoreboard;
        inverse_t pending[$];
        int       mismatches;
        int       n_checked;
        int       n_singular;
        int       n_clipped;

        // Rounded (ties away from zero) num/den clipped to the output width.
        static function automatic fix_t div_round_clip(wide_t num, wide_t den, inout logic sat);
            logic [255:0] n, d, q, r;
            logic         neg;
            logic [255:0] lim;
            fix_t         v;
            neg = (num < 0) != (den < 0);
            n   = (num < 0) ? -num : num;
            d   = (den < 0) ? -den : den;
            q   = n / d;
            r   = n % d;
            if ((r << 1) >= d)
                q = q + 1;
            lim = neg ? (256'd1 << (DATA_BITS-1)) : ((256'd1 << (DATA_BITS-1)) - 1);
            if (q > lim)
            begin
                sat = 1'b1;
                v = neg ? {1'b1, {(DATA_BITS-1){1'b0}}} : {1'b0, {(DATA_BITS-1){1'b1}}};
            end
            else
            begin
                v = neg ? -q[DATA_BITS-1:0] : q[DATA_BITS-1:0];
            end
            return v;
        endfunction

        static function automatic inverse_t invert(matrix_t m);
            wide_t    a00, a01, a02, a11, a12, a22;
            wide_t    c00, c01, c02, c11, c12, c22, d, scale;
            inverse_t e;
            logic     sat;
            a00 = m.m00; a01 = m.m01; a02 = m.m02;
            a11 = m.m11; a12 = m.m12; a22 = m.m22;
            c00 = a11*a22 - a12*a12;
            c01 = a02*a12 - a01*a22;
            c02 = a01*a12 - a02*a11;
            c11 = a00*a22 - a02*a02;
            c12 = a01*a02 - a00*a12;
            c22 = a00*a11 - a01*a01;
            d   = a00*c00 + a01*c01 + a02*c02;
            e = '{default: '0};
            if (d == 0)
            begin
                e.singular = 1'b1;
                return e;
            end
            sat   = 1'b0;
            scale = wide_t'(1) <<< (2*FRAC_BITS);
            e.det_value = div_round_clip(d, scale, sat);
            e.inv00 = div_round_clip(c00 * scale, d, sat);
            e.inv01 = div_round_clip(c01 * scale, d, sat);
            e.inv02 = div_round_clip(c02 * scale, d, sat);
            e.inv11 = div_round_clip(c11 * scale, d, sat);
            e.inv12 = div_round_clip(c12 * scale, d, sat);
            e.inv22 = div_round_clip(c22 * scale, d, sat);
            e.saturated = sat;
            return e;
        endfunction

        function void note_matrix(matrix_t m);
            inverse_t e;
            e = invert(m);
            if (e.singular) n_singular++;
            if (e.saturated) n_clipped++;
            pending.push_back(e);
        endfunction

        function void field(string name, logic [DATA_BITS-1:0] exp, logic [DATA_BITS-1:0] act);
            if (exp !== act)
            begin
                mismatches++;
                $display("%0t: %s expected %h got %h", $time, name, exp, act);
            end
        endfunction

        function void check_result(inverse_t got);
            inverse_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transfer with nothing outstanding, det %h",
                         $time, got.det_value);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            field("det_value", e.det_value, got.det_value);
            field("inv00", e.inv00, got.inv00);
            field("inv01", e.inv01, got.inv01);
            field("inv02", e.inv02, got.inv02);
            field("inv11", e.inv11, got.inv11);
            field("inv12", e.inv12, got.inv12);
            field("inv22", e.inv22, got.inv22);
            field("singular", e.singular, got.singular);
            field("saturated", e.saturated, got.saturated);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    s3i_mat_if #(.DATA_BITS(DATA_BITS)) mat_if ();
    s3i_res_if #(.DATA_BITS(DATA_BITS)) res_if ();

    symmetric_3x3_inverse #(
        .DATA_BITS(DATA_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .mat  (mat_if.sink),
        .res  (res_if.source)
    );

    inverse_scoreboard sb;

    int  tx_idle_pct;      // chance per cycle that the sender leaves a gap
    int  rx_idle_pct;      // chance per cycle that the receiver drops ready
    bit  hold_request;     // asks the receiver for one long stall
    int  idle_count;
    int  n_sent;

    // Clock: 8 ns period.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Everything driven to a known value from time zero.
    initial
    begin
        rst_n        = 1'b0;
        mat_if.valid = 1'b0;
        mat_if.m00   = '0;
        mat_if.m01   = '0;
        mat_if.m02   = '0;
        mat_if.m11   = '0;
        mat_if.m12   = '0;
        mat_if.m22   = '0;
        res_if.ready = 1'b0;
    end

    // Receiver: ready changes on the falling edge. A hold request gives one
    // long stretch with ready low so the pipe fills and backs up the input.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready = 1'b0;
            end
            else
                res_if.ready = rst_n && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result monitor: sampled on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            inverse_t got;
            got.det_value = res_if.det_value;
            got.inv00     = res_if.inv00;
            got.inv01     = res_if.inv01;
            got.inv02     = res_if.inv02;
            got.inv11     = res_if.inv11;
            got.inv12     = res_if.inv12;
            got.inv22     = res_if.inv22;
            got.singular  = res_if.singular;
            got.saturated = res_if.saturated;
            sb.check_result(got);
        end
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (mat_if.valid && mat_if.ready) || (res_if.valid && res_if.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one matrix: random gap first, then hold valid until the transfer.
    task automatic send_matrix(matrix_t m);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            mat_if.valid = 1'b0;
            @(negedge clk);
        end
        mat_if.valid = 1'b1;
        mat_if.m00   = m.m00;
        mat_if.m01   = m.m01;
        mat_if.m02   = m.m02;
        mat_if.m11   = m.m11;
        mat_if.m12   = m.m12;
        mat_if.m22   = m.m22;
        do
            @(posedge clk);
        while (!mat_if.ready);
        sb.note_matrix(m);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic matrix_t mk(fix_t a, fix_t b, fix_t c, fix_t d, fix_t e, fix_t f);
        matrix_t m;
        m.m00 = a; m.m01 = b; m.m02 = c; m.m11 = d; m.m12 = e; m.m22 = f;
        return m;
    endfunction

    // Value near one in magnitude: a well-conditioned entry with random fraction.
    function automatic fix_t near_unit();
        fix_t v;
        v = fix_t'($urandom_range(32'h0004_0000, 32'h0000_4000));
        return $urandom_range(1) ? -v : v;
    endfunction

    // Random matrix drawn from a spread of shapes so every path gets exercised.
    function automatic matrix_t random_matrix();
        matrix_t m;
        fix_t    s;
        int      kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1:    // fully random bits
                m = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            2, 3, 4: // diagonally dominant, sensible inverse
            begin
                m = mk(near_unit() * 4, near_unit(), near_unit(),
                       near_unit() * 4, near_unit(), near_unit() * 4);
            end
            5:       // small entries: tiny determinant, clipping inverse
                m = mk($signed($urandom_range(64)) - 32, $signed($urandom_range(64)) - 32,
                       $signed($urandom_range(64)) - 32, $signed($urandom_range(64)) - 32,
                       $signed($urandom_range(64)) - 32, $signed($urandom_range(64)) - 32);
            6:       // rank one: exactly singular
            begin
                s = $signed($urandom_range(2000)) - 1000;
                m = mk(s, s, s, s, s, s);
            end
            7:       // a zero row and column
                m = mk(near_unit(), near_unit(), '0, near_unit(), '0, '0);
            8:       // large entries: determinant clips
                m = mk($urandom | 32'h4000_0000, near_unit(), near_unit(),
                       $urandom | 32'h4000_0000, near_unit(), $urandom | 32'h4000_0000);
            default: // sparse random bits, many exact zero cofactors
                m = mk($urandom & $urandom, $urandom & $urandom & $urandom, '0,
                       $urandom & $urandom, $urandom & $urandom & $urandom,
                       $urandom & $urandom);
        endcase
        return m;
    endfunction

    initial
    begin : stimulus
        fix_t one, mx, mn;
        int   i;
        sb           = new();
        tx_idle_pct  = 36;
        rx_idle_pct  = 45;
        hold_request = 1'b0;
        n_sent       = 0;
        one = fix_t'(32'h0001_0000);
        mx  = fix_t'(32'h7FFF_FFFF);
        mn  = fix_t'(32'h8000_0000);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, zero determinant, tiny determinant, clipping.
        send_matrix(mk('0, '0, '0, '0, '0, '0));            // all zero: singular
        send_matrix(mk(one, '0, '0, one, '0, one));         // identity
        send_matrix(mk(-one, '0, '0, -one, '0, -one));      // negative det
        send_matrix(mk(one * 2, '0, '0, one * 4, '0, one / 2));
        send_matrix(mk(mx, mx, mx, mx, mx, mx));            // rank one
        send_matrix(mk(mn, mn, mn, mn, mn, mn));
        send_matrix(mk(mx, '0, '0, mx, '0, mx));            // det clips high
        send_matrix(mk(mn, '0, '0, mn, '0, mn));            // det clips low
        send_matrix(mk(mn, mx, mn, mx, mn, mx));
        send_matrix(mk(mx, mn, mx, mn, mx, mn));
        send_matrix(mk(fix_t'(1), '0, '0, fix_t'(1), '0, fix_t'(1)));    // tiny det
        send_matrix(mk(fix_t'(-1), '0, '0, fix_t'(1), '0, fix_t'(1)));
        send_matrix(mk(one, one, '0, one, '0, one));        // off-diagonal singular
        send_matrix(mk(one * 2, one, '0, one * 2, one, one * 2));
        send_matrix(mk(one, '0, one, one, '0, one));
        send_matrix(mk(one * 3, one, one, one * 3, one, one * 3));
        send_matrix(mk(fix_t'(32'h0000_8000), '0, '0, fix_t'(32'h0000_8000), '0,
                       fix_t'(32'h0000_8000)));             // 0.5 on the diagonal
        send_matrix(mk(fix_t'(32'h0003_0000), '0, '0, fix_t'(32'h0003_0000), '0,
                       fix_t'(32'h0003_0000)));             // inexact quotient
        send_matrix(mk(fix_t'(32'hFFFF_FFFF), fix_t'(32'h5555_5555), fix_t'(32'hAAAA_AAAA),
                       fix_t'(32'h0F0F_0F0F), fix_t'(32'hF0F0_F0F0), fix_t'(32'h0000_0001)));

        // Random, three idling phases; long output stall at the start of the last.
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                tx_idle_pct = 45;
                rx_idle_pct = 36;
            end
            if (i == (2 * N_RANDOM) / 3)
            begin
                tx_idle_pct  = 0;
                rx_idle_pct  = 0;
                hold_request = 1'b1;
            end
            send_matrix(random_matrix());
        end
        mat_if.valid = 1'b0;

        // Drain; the watchdog catches a hung block.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d matrices, checked %0d results (%0d singular, %0d clipped).",
                 n_sent, sb.n_checked, sb.n_singular, sb.n_clipped);
        $display("Covered three idling mixes and one long output stall with input back-pressure.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
